[design/lruc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LRU key/value cache.
// Used by lruc_cell, lru_key_value_cache and lruc_checker; depends on nothing.
package lruc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 2;

  localparam logic [CAP_W-1:0]      CAP_RESET    = CAP_W'(16);
  localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = '0;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // One cache entry as it moves along the row of cells.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Update applied to the whole row together.
  typedef struct packed {
    logic touch;   // hit: move the matching entry to the head
    logic insert;  // new key, room left: every valid entry moves down one
    logic evict;   // new key, full: the last valid entry drops off
  } op_t;

endpackage

[design/lruc_cell.sv]
`timescale 1ns / 1ps
// One position of the recency-ordered entry row; position 0 is most recent.
// Depends on lruc_pkg for entry_t and op_t.
module lruc_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lruc_pkg::op_t           op,
  input  lruc_pkg::entry_t        prev_entry,
  input  logic                    next_valid,
  input  logic [lruc_pkg::KEY_W-1:0] lookup_key,
  input  logic                    match_after_i,
  output logic                    match_after_o,
  input  logic [lruc_pkg::VAL_W-1:0] hit_val_i,
  output logic [lruc_pkg::VAL_W-1:0] hit_val_o,
  input  logic [lruc_pkg::KEY_W-1:0] last_key_i,
  output logic [lruc_pkg::KEY_W-1:0] last_key_o,
  output lruc_pkg::entry_t        entry_o
);
  import lruc_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             match;
  logic             is_last;
  logic             shift;

  // Local compare; the hit flag ripples toward the head of the row.
  assign match         = valid_r && (key_r == lookup_key);
  assign match_after_o = match_after_i | match;

  // The last valid entry is the least recent one.
  assign is_last    = valid_r && !next_valid;
  assign hit_val_o  = hit_val_i | (match ? value_r : '0);
  assign last_key_o = last_key_i | (is_last ? key_r : '0);

  // Take the neighbor's entry when the update spans this position.
  assign shift = (op.touch && match_after_o) ||
                 (op.insert && prev_entry.valid) ||
                 (op.evict && valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_entry.valid;
    end
  end

  // Key and value need no reset: they are only looked at while valid.
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_entry.key;
      value_r <= prev_entry.value;
    end
  end

  assign entry_o = '{valid: valid_r, key: key_r, value: value_r};

endmodule

[design/lru_key_value_cache.sv]
`timescale 1ns / 1ps
// Top level of the LRU key/value cache: APB capacity register, cell row, result register.
// Depends on lruc_pkg and lruc_cell.

// The cache takes one get or put request per clock cycle: a request is taken when start
// is high and busy is low, and its result appears on the out_ ports, marked by out_valid,
// in the following cycle for exactly one cycle. busy is high only in the first cycle after
// reset. The result cannot be held off, so it must be captured when out_valid is high.
// Entries are kept in a row of cells sorted by recency; the key compare ripples through
// the whole row and the row shifts in the same cycle, and that ripple sets the clock rate.
module lru_key_value_cache #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic signed [lruc_pkg::KEY_W-1:0] in_key,
  input  logic signed [lruc_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [lruc_pkg::VAL_W-1:0] out_read_value,
  output logic                          out_evicted,
  output logic signed [lruc_pkg::KEY_W-1:0] out_evicted_key,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lruc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lruc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lruc_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import lruc_pkg::*;

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r;
  logic             busy_r;
  logic             accept;
  logic             hit;
  logic             full;
  logic [CMP_W-1:0] cap_eff;
  op_t              op;
  entry_t           head;

  entry_t           ent    [ENTRIES];
  logic             nvalid [ENTRIES];
  logic             mchain [ENTRIES+1];
  logic [VAL_W-1:0] vchain [ENTRIES+1];
  logic [KEY_W-1:0] kchain [ENTRIES+1];

  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic             out_evicted_r;
  logic [KEY_W-1:0] out_evicted_key_r;

  // Configuration register: single capacity register, always ready.
  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Capacity clamped to the range one to ENTRIES.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  assign full = CMP_W'(occ_r) >= cap_eff;

  // Request acceptance and the row update it triggers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;
  assign hit    = mchain[0];

  assign op.touch  = accept && hit;
  assign op.insert = accept && (in_kind == KIND_PUT) && !hit && !full;
  assign op.evict  = accept && (in_kind == KIND_PUT) && !hit && full;

  // New head entry: the requested key, with the put value or the value that was found.
  assign head.valid = 1'b1;
  assign head.key   = in_key;
  assign head.value = (in_kind == KIND_PUT) ? in_value : vchain[ENTRIES];

  // Row of cells, head at position 0.
  assign mchain[ENTRIES] = 1'b0;
  assign vchain[0]       = '0;
  assign kchain[0]       = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      assign nvalid[i] = 1'b0;
    end else begin : g_body
      assign nvalid[i] = ent[i+1].valid;
    end

    lruc_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op           (op),
      .prev_entry   ((i == 0) ? head : ent[(i == 0) ? 0 : i-1]),
      .next_valid   (nvalid[i]),
      .lookup_key   (in_key),
      .match_after_i(mchain[i+1]),
      .match_after_o(mchain[i]),
      .hit_val_i    (vchain[i]),
      .hit_val_o    (vchain[i+1]),
      .last_key_i   (kchain[i]),
      .last_key_o   (kchain[i+1]),
      .entry_o      (ent[i])
    );
  end

  // Occupancy grows only on an insert into a free position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (op.insert) begin
      occ_r <= occ_r + OCC_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r         <= hit;
      out_read_value_r  <= (in_kind == KIND_PUT) ? '0 :
                           (hit ? vchain[ENTRIES] : MISS_VALUE);
      out_evicted_r     <= op.evict;
      out_evicted_key_r <= op.evict ? kchain[ENTRIES] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

[design/lruc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lruc_pkg and lru_key_value_cache.
module lruc_port_checks (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_kind,
  input logic                            out_valid,
  input logic                            out_hit,
  input logic [lruc_pkg::VAL_W-1:0]      out_read_value,
  input logic                            out_evicted,
  input logic [lruc_pkg::KEY_W-1:0]      out_evicted_key
);
  import lruc_pkg::*;

  // Every request gets its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("request without a result in the next cycle");

  // No result appears without a request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a request");

  // An eviction only happens on a put that missed.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (!out_hit && $past(in_kind) == KIND_PUT))
    else $error("eviction on a hit or on a get");

  // Without an eviction the evicted key reads zero.
  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == '0))
    else $error("evicted key set without an eviction");

  // A get that misses returns all ones.
  a_get_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit && $past(in_kind) == KIND_GET) |-> (out_read_value == MISS_VALUE))
    else $error("get miss did not return minus one");

endmodule

bind lru_key_value_cache lruc_port_checks u_lruc_port_checks (.*);

[tb/lruc_checker.sv]
`timescale 1ns / 1ps
// Checker for the LRU key/value cache: watches the request, result and APB channels,
// predicts every result from its own copy of the cache and compares. Depends on lruc_pkg.
module lruc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            in_kind,
  input  logic [lruc_pkg::KEY_W-1:0]      in_key,
  input  logic [lruc_pkg::VAL_W-1:0]      in_value,
  input  logic                            out_valid,
  input  logic                            out_hit,
  input  logic [lruc_pkg::VAL_W-1:0]      out_read_value,
  input  logic                            out_evicted,
  input  logic [lruc_pkg::KEY_W-1:0]      out_evicted_key,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lruc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lruc_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [lruc_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              outstanding,
  output int                              n_results,
  output int                              n_hits,
  output int                              n_evictions
);
  import lruc_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lookup_result_t;

  // Shadow copy of the cache contents and the capacity register.
  logic [KEY_W-1:0] slot_key   [SLOTS];
  logic [VAL_W-1:0] slot_value [SLOTS];
  logic             slot_valid [SLOTS];
  int               slot_rank  [SLOTS];
  int               used_slots;
  logic [CAP_W-1:0] capacity_reg;

  lookup_result_t pending_results[$];

  // Make slot s the most recent one; entries more recent than it age by one.
  function automatic void promote(input int s);
    int r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one get or put to the shadow cache and return what the block should report.
  function automatic lookup_result_t lookup_and_update(input logic kind,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [VAL_W-1:0] value);
    lookup_result_t res;
    int match;
    int slot;
    int cap_eff;
    res = '0;
    match = -1;
    slot = -1;
    cap_eff = (capacity_reg == 0) ? 1 : ((capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg));
    for (int i = 0; i < SLOTS; i++) begin
      if (match < 0 && slot_valid[i] && slot_key[i] == key) match = i;
    end
    if (kind == KIND_GET) begin
      if (match >= 0) begin
        res.hit = 1'b1;
        res.read_value = slot_value[match];
        promote(match);
      end else begin
        res.read_value = MISS_VALUE;
      end
    end else if (match >= 0) begin
      res.hit = 1'b1;
      slot_value[match] = value;
      promote(match);
    end else begin
      // Full (or over a lowered capacity): the oldest entry gives up its slot.
      if (used_slots >= cap_eff) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
        end
        if (slot >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = slot_key[slot];
          promote(slot);
        end
      end
      // Room left: take the lowest free slot and age every held entry.
      if (slot < 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) slot_rank[i]++;
          end
          slot_valid[slot] = 1'b1;
          slot_rank[slot] = 0;
          used_slots++;
        end
      end
      if (slot >= 0) begin
        slot_key[slot] = key;
        slot_value[slot] = value;
      end
    end
    return res;
  endfunction

  // Predict at each accepted request, compare at each result strobe.
  always @(posedge clk) begin
    lookup_result_t exp_res;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i] = 0;
      end
      used_slots = 0;
      capacity_reg = CAP_RESET;
      pending_results.delete();
      fail_count <= 0;
      n_results <= 0;
      n_hits <= 0;
      n_evictions <= 0;
    end else begin
      // Configuration port: register write and read-back.
      if (psel && penable && pready && paddr == ADDR_CAPACITY) begin
        if (pwrite) begin
          capacity_reg = pwdata[CAP_W-1:0];
        end else if (prdata !== APB_DATA_W'(capacity_reg)) begin
          $error("prdata: expected %0d, got %0d", capacity_reg, prdata);
          errs++;
        end
      end

      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          errs++;
        end else begin
          exp_res = pending_results.pop_front();
          n_results <= n_results + 1;
          if (out_hit !== exp_res.hit) begin
            $error("hit: expected %0d, got %0d", exp_res.hit, out_hit);
            errs++;
          end
          if (out_read_value !== exp_res.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(exp_res.read_value), $signed(out_read_value));
            errs++;
          end
          if (out_evicted !== exp_res.evicted) begin
            $error("evicted: expected %0d, got %0d", exp_res.evicted, out_evicted);
            errs++;
          end
          if (out_evicted_key !== exp_res.evicted_key) begin
            $error("evicted_key: expected %0d, got %0d",
                   $signed(exp_res.evicted_key), $signed(out_evicted_key));
            errs++;
          end
          if (exp_res.hit) n_hits <= n_hits + 1;
          if (exp_res.evicted) n_evictions <= n_evictions + 1;
        end
      end

      if (start && !busy) begin
        pending_results.push_back(lookup_and_update(in_kind, in_key, in_value));
      end

      // One update of the failure count per cycle, however many fields differed.
      if (errs != 0) fail_count <= fail_count + errs;
    end
    outstanding <= pending_results.size();
  end

endmodule

[tb/tb_lru_key_value_cache.sv]
`timescale 1ns / 1ps
// Top of the LRU key/value cache testbench: clock, reset, request and APB stimulus, verdict.
// Depends on lruc_pkg, lru_key_value_cache and lruc_checker.
module tb_lru_key_value_cache;
  import lruc_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS  = 127;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_kind;
  logic [KEY_W-1:0]      in_key;
  logic [VAL_W-1:0]      in_value;
  logic                  out_valid;
  logic                  out_hit;
  logic [VAL_W-1:0]      out_read_value;
  logic                  out_evicted;
  logic [KEY_W-1:0]      out_evicted_key;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int n_results;
  int n_hits;
  int n_evictions;
  int sender_idle_pct;
  int capacity_settings;
  int stall_cycles;

  lru_key_value_cache dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_key, .in_value,
    .out_valid, .out_hit, .out_read_value, .out_evicted, .out_evicted_key,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lruc_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_kind, .in_key, .in_value,
    .out_valid, .out_hit, .out_read_value, .out_evicted, .out_evicted_key,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .outstanding, .n_results, .n_hits, .n_evictions
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a long run of cycles with no traffic at all means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("lru_key_value_cache regression: fail");
        $finish;
      end
    end
  end

  // Issue one request, idling first at the current rate; returns at a falling edge.
  task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stop issuing and wait until every result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, then a cycle with the bus released.
  task automatic apb_transfer(input logic write, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= ADDR_CAPACITY;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Change the capacity with the cache idle, then read it back.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    apb_transfer(1'b1, APB_DATA_W'(cap));
    apb_transfer(1'b0, '0);
    capacity_settings++;
  endtask

  // Random phase: keys mostly from a small pool so that hits and evictions are frequent.
  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int idle_pct);
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    int cap_eff;
    int pool_size;
    set_capacity(cap);
    sender_idle_pct = idle_pct;
    cap_eff = (cap == 0) ? 1 : ((cap > ENTRIES_DEF) ? ENTRIES_DEF : int'(cap));
    pool_size = cap_eff + $urandom_range(1, 4);
    for (int i = 0; i < pool_size; i++) begin
      case ($urandom_range(11))
        0: key_pool.push_back(32'h8000_0000);
        1: key_pool.push_back(32'h7fff_ffff);
        2: key_pool.push_back('1);
        default: key_pool.push_back($urandom);
      endcase
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(pool_size - 1)] : $urandom;
      send_request($urandom_range(1) ? KIND_PUT : KIND_GET, key, $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [RANDOM_PHASES];
    int idle_pct;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_GET;
    in_key = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sender_idle_pct = 0;
    capacity_settings = 0;
    phase_caps = '{5'd1, 5'd16, 5'd5, 5'd31, 5'd0, 5'd3,
                   5'd16, 5'd8, 5'd2, 5'd1, 5'd12, 5'd16};
    phase_caps[9] = CAP_W'($urandom_range(0, 31));
    phase_caps[11] = CAP_W'($urandom_range(0, 31));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty cache, extreme keys and values, overwrite, a stored -1.
    send_request(KIND_GET, '0, '0);
    send_request(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(KIND_PUT, '0, '0);
    send_request(KIND_PUT, '1, '1);
    send_request(KIND_GET, 32'h8000_0000, '0);
    send_request(KIND_GET, '1, '0);
    send_request(KIND_PUT, 32'h7fff_ffff, 32'h1234_5678);
    send_request(KIND_GET, 32'd5, '1);

    // Capacity lowered under four held entries: new keys evict, occupancy holds.
    set_capacity(5'd2);
    send_request(KIND_PUT, 32'd100, 32'd1);
    send_request(KIND_PUT, 32'd101, 32'd2);
    send_request(KIND_GET, 32'h7fff_ffff, '0);

    // Capacity zero behaves as one.
    set_capacity(5'd0);
    send_request(KIND_PUT, 32'd200, 32'hdead_beef);

    // Capacity above the store saturates: fill all sixteen slots, then evict.
    set_capacity(5'd31);
    for (int i = 0; i < 13; i++) begin
      send_request(KIND_PUT, 32'd300 + i, $urandom);
    end

    // Random phases: sender idles lightly, then heavily, then not at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct = (p < 4) ? 11 : ((p < 8) ? 72 : 0);
      run_random_phase(phase_caps[p], idle_pct);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Checked %0d requests over %0d capacity settings.", n_results, capacity_settings);
    $display("Of those, %0d hit and %0d evicted an entry.", n_hits, n_evictions);
    if (fail_count == 0) begin
      $display("lru_key_value_cache regression: pass");
    end else begin
      $display("lru_key_value_cache regression: fail");
    end
    $finish;
  end

endmodule
